// ----- rtl/core/cks_pkg.sv -----
// Shared types, widths and register codes for the color key desaturation pipeline.
package cks_pkg;

    localparam int CH_W      = 8;
    localparam int RADIUS_W  = 13;
    localparam int RR_W      = 2 * RADIUS_W;
    localparam int D2_W      = 18;
    localparam int SQ_SHIFT  = 16;
    localparam int ROOT_W    = 17;
    localparam int REM_W     = ROOT_W + 3;
    localparam int QT_W      = 13;
    localparam int NUM_W     = ROOT_W + 8;
    localparam int PROD_W    = QT_W + CH_W;
    localparam int GRAY_SUM_W = 13;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [QT_W-1:0]     P_ONE        = QT_W'(4096);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(16);

    typedef enum logic [2:0] {
        REG_KEY_RED   = 3'd0,
        REG_KEY_GREEN = 3'd1,
        REG_KEY_BLUE  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_SOFT_MODE = 3'd4,
        REG_BYPASS    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } pixel_out_t;

    // Pixel data that rides along the pipeline
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] gray;
        logic            in_key;
    } side_t;

    typedef struct packed {
        logic [CH_W-1:0]     key_red;
        logic [CH_W-1:0]     key_green;
        logic [CH_W-1:0]     key_blue;
        logic [RADIUS_W-1:0] radius;
        logic                soft_mode;
        logic                bypass;
    } cfg_t;

endpackage

// ----- rtl/core/cks_front.sv -----
// Front stages: channel distances, gray level, squared distance and key test.
module cks_front
    import cks_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  cfg_t            cfg,
    input  logic [RR_W-1:0] rr,
    input  logic            in_valid,
    input  pixel_in_t       in_data,
    output logic            out_valid,
    output side_t           out_side,
    output logic [D2_W-1:0] out_d2
);

    logic            v1_reg, v2_reg, v3_reg;
    pixel_in_t       px1_reg;
    logic [CH_W-1:0] dr1_reg, dg1_reg, db1_reg, gray1_reg;
    logic [CH_W-1:0] dr1_next, dg1_next, db1_next, gray1_next;
    logic [GRAY_SUM_W-1:0] gray_sum;
    side_t           side2_reg, side2_next, side3_reg, side3_next;
    logic [D2_W-1:0] d2_2_reg, d2_2_next, d2_3_reg;
    logic [2*CH_W-1:0] sq_r, sq_g, sq_b;

    // Stage one: absolute channel distances and weighted gray
    always_comb
    begin
        dr1_next = (in_data.in_red >= cfg.key_red) ? in_data.in_red - cfg.key_red
                                                    : cfg.key_red - in_data.in_red;
        dg1_next = (in_data.in_green >= cfg.key_green) ? in_data.in_green - cfg.key_green
                                                        : cfg.key_green - in_data.in_green;
        db1_next = (in_data.in_blue >= cfg.key_blue) ? in_data.in_blue - cfg.key_blue
                                                      : cfg.key_blue - in_data.in_blue;
        gray_sum = GRAY_SUM_W'(11) * {5'b0, in_data.in_red}
                 + {1'b0, in_data.in_green, 4'b0}
                 + GRAY_SUM_W'(5) * {5'b0, in_data.in_blue};
        gray1_next = gray_sum[GRAY_SUM_W-1:5];
    end

    // Stage two: sum of squares
    always_comb
    begin
        sq_r = dr1_reg * dr1_reg;
        sq_g = dg1_reg * dg1_reg;
        sq_b = db1_reg * db1_reg;
        d2_2_next = {2'b0, sq_r} + {2'b0, sq_g} + {2'b0, sq_b};
        side2_next.red    = px1_reg.in_red;
        side2_next.green  = px1_reg.in_green;
        side2_next.blue   = px1_reg.in_blue;
        side2_next.alpha  = px1_reg.in_alpha;
        side2_next.gray   = gray1_reg;
        side2_next.in_key = 1'b0;
    end

    // Stage three: compare scaled distance against the squared radius
    always_comb
    begin
        side3_next = side2_reg;
        side3_next.in_key = ({d2_2_reg, 8'b0} <= rr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg   <= in_data;
            dr1_reg   <= dr1_next;
            dg1_reg   <= dg1_next;
            db1_reg   <= db1_next;
            gray1_reg <= gray1_next;
            side2_reg <= side2_next;
            d2_2_reg  <= d2_2_next;
            side3_reg <= side3_next;
            d2_3_reg  <= d2_2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign out_d2    = d2_3_reg;

endmodule

// ----- rtl/core/cks_sqrt.sv -----
// Pipelined integer square root of the scaled distance, one root bit per stage.
module cks_sqrt
    import cks_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic [D2_W-1:0]   in_d2,
    output logic              out_valid,
    output side_t             out_side,
    output logic [ROOT_W-1:0] out_root
);

    localparam int V_W = D2_W + SQ_SHIFT;

    logic              vld_reg  [ROOT_W];
    side_t             side_reg [ROOT_W];
    logic [D2_W-1:0]   d2_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic              vld_prev;
        side_t             side_prev;
        logic [D2_W-1:0]   d2_prev;
        logic [ROOT_W-1:0] root_prev, root_next;
        logic [REM_W-1:0]  rem_prev, rem_next;
        logic [V_W-1:0]    v_full;
        logic [REM_W+1:0]  rem_sh, trial;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign side_prev = in_side;
            assign d2_prev   = in_d2;
            assign root_prev = '0;
            assign rem_prev  = '0;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign d2_prev   = d2_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
        end

        // Bring in the next bit pair and try to set the next root bit
        always_comb
        begin
            v_full = {d2_prev, {SQ_SHIFT{1'b0}}};
            rem_sh = {rem_prev, v_full[V_W-1-2*k -: 2]};
            trial  = (REM_W+2)'({root_prev, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_prev[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_prev[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                d2_reg[k]   <= d2_prev;
                root_reg[k] <= root_next;
                rem_reg[k]  <= rem_next;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

// ----- rtl/core/cks_div.sv -----
// Pipelined restoring divider for the blend fraction, one quotient bit per stage.
module cks_div
    import cks_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [RADIUS_W-1:0] radius,
    input  logic                in_valid,
    input  side_t               in_side,
    input  logic [ROOT_W-1:0]   in_root,
    output logic                out_valid,
    output side_t               out_side,
    output logic [QT_W-1:0]     out_p
);

    logic              vld_reg  [QT_W];
    side_t             side_reg [QT_W];
    logic [NUM_W-1:0]  num_reg  [QT_W];
    logic [QT_W-1:0]   quo_reg  [QT_W];
    logic [RADIUS_W-1:0] rem_reg [QT_W];

    for (genvar k = 0; k < QT_W; k++)
    begin : g_step
        logic                vld_prev;
        side_t               side_prev;
        logic [NUM_W-1:0]    num_prev;
        logic [QT_W-1:0]     quo_prev, quo_next;
        logic [RADIUS_W-1:0] rem_prev, rem_next;
        logic [RADIUS_W:0]   rem_sh;

        // Quotient stays below 2**QT_W for pixels inside the key
        if (k == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign side_prev = in_side;
            assign num_prev  = {in_root, 8'b0};
            assign quo_prev  = '0;
            assign rem_prev  = RADIUS_W'({in_root, 8'b0} >> QT_W);
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign num_prev  = num_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
        end

        // Shift in one numerator bit and subtract the radius where it fits
        always_comb
        begin
            rem_sh = {rem_prev, num_prev[QT_W-1-k]};
            if (rem_sh >= {1'b0, radius})
            begin
                rem_next = RADIUS_W'(rem_sh - {1'b0, radius});
                quo_next = {quo_prev[QT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = RADIUS_W'(rem_sh);
                quo_next = {quo_prev[QT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                num_reg[k]  <= num_prev;
                quo_reg[k]  <= quo_next;
                rem_reg[k]  <= rem_next;
            end
        end
    end

    // Zero radius gives no blend; clamp to one
    always_comb
    begin
        if (radius == '0)
            out_p = '0;
        else if (quo_reg[QT_W-1] > P_ONE)
            out_p = P_ONE;
        else
            out_p = quo_reg[QT_W-1];
    end

    assign out_valid = vld_reg[QT_W-1];
    assign out_side  = side_reg[QT_W-1];

endmodule

// ----- rtl/core/cks_blend.sv -----
// Blend stages: scale channel-to-gray distances and select the final pixel.
module cks_blend
    import cks_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  cfg_t            cfg,
    input  logic            in_valid,
    input  side_t           in_side,
    input  logic [QT_W-1:0] in_p,
    output logic            out_valid,
    output pixel_out_t      out_data
);

    logic              v1_reg, v2_reg;
    side_t             side1_reg;
    logic [CH_W-1:0]   chan [3];
    logic [CH_W-1:0]   chan1 [3];
    logic [CH_W-1:0]   mag [3];
    logic              neg_next [3];
    logic              neg_reg [3];
    logic [PROD_W-1:0] prod_next [3];
    logic [PROD_W-1:0] prod_reg [3];
    logic [CH_W-1:0]   mixed [3];
    logic [CH_W-1:0]   step [3];
    pixel_out_t        data_reg, data_next;

    assign chan[0]  = in_side.red;
    assign chan[1]  = in_side.green;
    assign chan[2]  = in_side.blue;
    assign chan1[0] = side1_reg.red;
    assign chan1[1] = side1_reg.green;
    assign chan1[2] = side1_reg.blue;

    // Stage one: distance to gray times the blend fraction
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i]  = (in_side.gray < chan[i]);
            mag[i]       = neg_next[i] ? chan[i] - in_side.gray : in_side.gray - chan[i];
            prod_next[i] = PROD_W'(in_p) * PROD_W'(mag[i]);
        end
    end

    // Stage two: apply the step and pick the output
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            step[i]  = prod_reg[i][PROD_W-2:QT_W-1];
            mixed[i] = neg_reg[i] ? chan1[i] - step[i] : chan1[i] + step[i];
        end
        data_next.out_alpha = side1_reg.alpha;
        if (cfg.bypass || (side1_reg.in_key && !cfg.soft_mode))
        begin
            data_next.out_red   = side1_reg.red;
            data_next.out_green = side1_reg.green;
            data_next.out_blue  = side1_reg.blue;
        end
        else if (side1_reg.in_key)
        begin
            data_next.out_red   = mixed[0];
            data_next.out_green = mixed[1];
            data_next.out_blue  = mixed[2];
        end
        else
        begin
            data_next.out_red   = side1_reg.gray;
            data_next.out_green = side1_reg.gray;
            data_next.out_blue  = side1_reg.gray;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= in_side;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i]  <= neg_next[i];
                prod_reg[i] <= prod_next[i];
            end
            data_reg <= data_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/core/color_key_desaturate.sv -----
// Top level: register port, pipeline enable and the four pipeline sections.
//
//   port group    | direction | transfer when
//   in_*          | in        | in_valid && in_ready
//   out_*         | out       | out_valid && out_ready
//   apb (p*)      | in        | psel && penable && pwrite (pready always high)
//
// One pixel per cycle sustained while the output is not stalled; each pixel passes from input transfer
// to output valid through 3 front stages, 17 square-root stages, 13 divider stages
// and 2 blend stages.
// Reset clears all valid bits and loads register defaults (radius 16).
// A stalled output register holds the whole pipeline, so in_ready follows
// out_ready while out_valid is high; no pixel is lost or repeated.
module color_key_desaturate
    import cks_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  pixel_in_t         in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pixel_out_t        out_data
);

    cfg_t            cfg_reg;
    logic [RR_W-1:0] rr_reg;
    logic            en;
    logic            wr;
    reg_idx_t        idx;

    logic            f_valid, s_valid, d_valid;
    side_t           f_side, s_side, d_side;
    logic [D2_W-1:0] f_d2;
    logic [ROOT_W-1:0] s_root;
    logic [QT_W-1:0] d_p;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign en     = !out_valid || out_ready;
    assign in_ready = en;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_red   <= '0;
            cfg_reg.key_green <= '0;
            cfg_reg.key_blue  <= '0;
            cfg_reg.radius    <= RADIUS_RESET;
            cfg_reg.soft_mode <= 1'b0;
            cfg_reg.bypass    <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                REG_KEY_RED:   cfg_reg.key_red   <= pwdata[CH_W-1:0];
                REG_KEY_GREEN: cfg_reg.key_green <= pwdata[CH_W-1:0];
                REG_KEY_BLUE:  cfg_reg.key_blue  <= pwdata[CH_W-1:0];
                REG_RADIUS:    cfg_reg.radius    <= pwdata[RADIUS_W-1:0];
                REG_SOFT_MODE: cfg_reg.soft_mode <= pwdata[0];
                REG_BYPASS:    cfg_reg.bypass    <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Squared radius, refreshed every cycle
    always_ff @(posedge clk)
    begin
        rr_reg <= cfg_reg.radius * cfg_reg.radius;
    end

    // Register reads
    always_comb
    begin
        case (idx)
            REG_KEY_RED:   prdata = DATA_W'(cfg_reg.key_red);
            REG_KEY_GREEN: prdata = DATA_W'(cfg_reg.key_green);
            REG_KEY_BLUE:  prdata = DATA_W'(cfg_reg.key_blue);
            REG_RADIUS:    prdata = DATA_W'(cfg_reg.radius);
            REG_SOFT_MODE: prdata = DATA_W'(cfg_reg.soft_mode);
            REG_BYPASS:    prdata = DATA_W'(cfg_reg.bypass);
            default:       prdata = '0;
        endcase
    end

    cks_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .rr        (rr_reg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_d2    (f_d2)
    );

    cks_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_d2     (f_d2),
        .out_valid (s_valid),
        .out_side  (s_side),
        .out_root  (s_root)
    );

    cks_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .radius    (cfg_reg.radius),
        .in_valid  (s_valid),
        .in_side   (s_side),
        .in_root   (s_root),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_p     (d_p)
    );

    cks_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .in_p      (d_p),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // A held output must block new input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while output stalled");

    // Blend fraction never exceeds one
    a_p_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid |-> (d_p <= P_ONE))
        else $error("blend fraction out of range");

    // A stalled pipeline keeps the divider output steady
    a_stall_holds_div: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid && !en) |=> (d_valid && $stable(d_side)))
        else $error("divider stage changed during stall");
`endif

endmodule

// ----- verif/tb_color_key_desaturate.sv -----
// Self-checking testbench for color_key_desaturate: random pixels, APB setup, stalls.
`timescale 1ns / 1ps

module tb_color_key_desaturate;
    import cks_pkg::*;

    localparam int PIPE_LAT    = 35;
    localparam int STALL_LIMIT = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    pixel_in_t         in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    pixel_out_t        out_data;

    // Predictor copy of the register file
    logic [7:0]  key_r = 8'd0, key_g = 8'd0, key_b = 8'd0;
    logic [12:0] radius = 13'd16;
    logic        soft_en = 1'b0, bypass = 1'b0;

    pixel_in_t   pending_pixels[$];
    pixel_out_t  expected_pixels[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    bit          sender_hold = 1'b0;
    bit          stim_done = 1'b0;

    color_key_desaturate i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] blend(logic [7:0] c, logic [7:0] gray, logic [12:0] p);
        logic [8:0]  mag;
        logic [20:0] step;
        mag = (gray >= c) ? 9'(gray - c) : 9'(c - gray);
        step = (21'(p) * 21'(mag)) >> 12;
        return (gray >= c) ? 8'(c + step) : 8'(c - step);
    endfunction

    function automatic pixel_out_t desaturate(pixel_in_t px);
        pixel_out_t  res;
        logic [7:0]  dr, dg, db, gray;
        logic [63:0] d2, rr, s, q, v, bit_w, root;
        logic [12:0] p;
        res.out_alpha = px.in_alpha;
        res.out_red = px.in_red;
        res.out_green = px.in_green;
        res.out_blue = px.in_blue;
        if (bypass)
            return res;
        dr = (px.in_red >= key_r) ? px.in_red - key_r : key_r - px.in_red;
        dg = (px.in_green >= key_g) ? px.in_green - key_g : key_g - px.in_green;
        db = (px.in_blue >= key_b) ? px.in_blue - key_b : key_b - px.in_blue;
        d2 = 64'(dr) * dr + 64'(dg) * dg + 64'(db) * db;
        rr = 64'(radius) * radius;
        gray = 8'((11 * 32'(px.in_red) + 16 * 32'(px.in_green) + 5 * 32'(px.in_blue)) >> 5);
        if (256 * d2 > rr)
        begin
            res.out_red = gray;
            res.out_green = gray;
            res.out_blue = gray;
        end
        else if (soft_en)
        begin
            p = '0;
            if (radius != 0)
            begin
                // Integer square root by digit recurrence
                v = 65536 * d2;
                root = 0;
                bit_w = 64'd1 << 62;
                while (bit_w > v)
                    bit_w >>= 2;
                while (bit_w != 0)
                begin
                    if (v >= root + bit_w)
                    begin
                        v -= root + bit_w;
                        root = (root >> 1) + bit_w;
                    end
                    else
                        root >>= 1;
                    bit_w >>= 2;
                end
                s = root;
                q = (256 * s) / radius;
                p = (q > 4096) ? 13'd4096 : 13'(q);
            end
            res.out_red = blend(px.in_red, gray, p);
            res.out_green = blend(px.in_green, gray, p);
            res.out_blue = blend(px.in_blue, gray, p);
        end
        return res;
    endfunction

    // Driver: present queued pixels mostly back to back, with random gaps, sometimes short, sometimes long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() > 0 && !sender_hold)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_pixels.pop_front();
                    case ($urandom_range(0, 29))
                        0: gap_left <= $urandom_range(10, 50);
                        1, 2, 3, 4, 5, 6: gap_left <= $urandom_range(1, 3);
                        default: gap_left <= 0;
                    endcase
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Record expectation on each input transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_pixels.push_back(desaturate(in_data));
    end

    // Receiver stalls: mostly none, sometimes short, sometimes long
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: stall_left <= $urandom_range(10, 60);
                    1, 2, 3: stall_left <= $urandom_range(1, 3);
                    default: stall_left <= 0;
                endcase
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected output pixel %h", out_data);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_data.out_red !== want.out_red)
                begin
                    $error("out_red expected %0d got %0d", want.out_red, out_data.out_red);
                    errors++;
                end
                if (out_data.out_green !== want.out_green)
                begin
                    $error("out_green expected %0d got %0d", want.out_green, out_data.out_green);
                    errors++;
                end
                if (out_data.out_blue !== want.out_blue)
                begin
                    $error("out_blue expected %0d got %0d", want.out_blue, out_data.out_blue);
                    errors++;
                end
                if (out_data.out_alpha !== want.out_alpha)
                begin
                    $error("out_alpha expected %0d got %0d", want.out_alpha, out_data.out_alpha);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** color_key_desaturate: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KEY_RED: key_r = value[7:0];
            REG_KEY_GREEN: key_g = value[7:0];
            REG_KEY_BLUE: key_b = value[7:0];
            REG_RADIUS: radius = value[12:0];
            REG_SOFT_MODE: soft_en = value[0];
            default: bypass = value[0];
        endcase
    endtask

    // Sample between edges so queue and valid state have settled
    task automatic drain();
        while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(negedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    task automatic configure(logic [7:0] kr, logic [7:0] kg, logic [7:0] kb,
                             logic [12:0] rad, bit sm, bit bp);
        drain();
        write_reg(REG_KEY_RED, 32'(kr));
        write_reg(REG_KEY_GREEN, 32'(kg));
        write_reg(REG_KEY_BLUE, 32'(kb));
        write_reg(REG_RADIUS, 32'(rad));
        write_reg(REG_SOFT_MODE, 32'(sm));
        write_reg(REG_BYPASS, 32'(bp));
    endtask

    function automatic pixel_in_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a);
        pixel_in_t px;
        px.in_red = r;
        px.in_green = g;
        px.in_blue = b;
        px.in_alpha = a;
        return px;
    endfunction

    // Pixels near the key exercise the in-key and soft paths
    task automatic queue_random(int count, int spread);
        pixel_in_t px;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                px = pixel_in_t'($urandom);
            else
            begin
                px.in_red = 8'(int'(key_r) + $urandom_range(0, 2 * spread) - spread);
                px.in_green = 8'(int'(key_g) + $urandom_range(0, 2 * spread) - spread);
                px.in_blue = 8'(int'(key_b) + $urandom_range(0, 2 * spread) - spread);
                px.in_alpha = 8'($urandom);
            end
            pending_pixels.push_back(px);
        end
    endtask

    initial
    begin
        int wait_cycles;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, channel extremes, exact key match
        pending_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd255));
        pending_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd255, 8'd0));
        pending_pixels.push_back(make_pixel(8'd1, 8'd0, 8'd0, 8'd170));
        pending_pixels.push_back(make_pixel(8'd255, 8'd0, 8'd0, 8'd85));
        pending_pixels.push_back(make_pixel(8'd0, 8'd255, 8'd0, 8'd1));
        pending_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd255, 8'd128));

        // Zero radius in soft mode: only an exact match keeps its color
        configure(8'd40, 8'd200, 8'd90, 13'd0, 1'b1, 1'b0);
        pending_pixels.push_back(make_pixel(8'd40, 8'd200, 8'd90, 8'd7));
        pending_pixels.push_back(make_pixel(8'd41, 8'd200, 8'd90, 8'd9));
        // Largest radius: every pixel in the key, soft blend
        configure(8'd255, 8'd0, 8'd255, 13'h1FFF, 1'b1, 1'b0);
        pending_pixels.push_back(make_pixel(8'd0, 8'd255, 8'd0, 8'd3));
        pending_pixels.push_back(make_pixel(8'd255, 8'd0, 8'd255, 8'd4));
        configure(8'd128, 8'd128, 8'd128, 13'd7072, 1'b0, 1'b0);
        pending_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd5));
        pending_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd255, 8'd6));
        // Bypass
        configure(8'd10, 8'd20, 8'd30, 13'd16, 1'b1, 1'b1);
        pending_pixels.push_back(make_pixel(8'd200, 8'd3, 8'd77, 8'd250));
        pending_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd0, 8'd0));

        // Random phases across settings
        for (int phase = 0; phase < 16; phase++)
        begin
            configure(8'($urandom), 8'($urandom), 8'($urandom),
                      (phase % 4 == 0) ? 13'($urandom) : 13'($urandom_range(0, 1200)),
                      phase[0], (phase % 7 == 6));
            queue_random(25, 40);
            // Hold the sender until all results are back
            if (phase == 5)
            begin
                while (pending_pixels.size() > 0 || in_valid)
                    @(negedge clk);
                sender_hold = 1'b1;
                while (expected_pixels.size() > 0)
                    @(negedge clk);
                sender_hold = 1'b0;
            end
            queue_random(25, 40);
        end

        drain();
        stim_done = 1'b1;
        wait_cycles = 0;
        while (expected_pixels.size() > 0 && wait_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (PIPE_LAT + 5) @(posedge clk);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("** color_key_desaturate: PASSED **");
        else
            $display("** color_key_desaturate: FAILED **");
        $finish;
    end

endmodule
